### design/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`default_nettype none

package b2da_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 6;
    localparam int MAX_IN_W       = 64;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] BCD_FIVE   = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ    = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } b2da_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit;
    } b2da_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic digits_one;
        logic out_free;
    } b2da_status_t;

endpackage

`default_nettype wire

### design/b2da_ctrl.sv
// controller state machine: sequences load, shift-add conversion and digit output
`default_nettype none

module b2da_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire b2da_pkg::b2da_status_t status,
    output b2da_pkg::b2da_cmd_t        cmd
);

    b2da_pkg::b2da_state_t state_reg;
    b2da_pkg::b2da_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = b2da_pkg::ST_CONVERT;
                end
            end
            b2da_pkg::ST_CONVERT: begin
                if (status.conv_last) begin
                    state_next = b2da_pkg::ST_SKIP;
                end
            end
            b2da_pkg::ST_SKIP: begin
                if (!status.top_zero || status.digits_one) begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT: begin
                if (status.out_free && status.digits_one) begin
                    state_next = b2da_pkg::ST_IDLE;
                end
            end
            default: state_next = b2da_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            b2da_pkg::ST_CONVERT: begin
                cmd.step = 1'b1;
            end
            b2da_pkg::ST_SKIP: begin
                cmd.skip = status.top_zero && !status.digits_one;
            end
            b2da_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/b2da_dp.sv
// datapath: binary shift register, bcd accumulator, digit counter and output register
`default_nettype none

module b2da_dp #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [b2da_pkg::MAX_IN_W-1:0] in_value,
    input  wire b2da_pkg::b2da_cmd_t           cmd,
    output b2da_pkg::b2da_status_t             status,
    output logic [b2da_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_last,
    output logic                               out_valid,
    input  wire logic                          out_ready
);

    localparam int NumDigits = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int BcdW      = NumDigits * b2da_pkg::DIGIT_W;
    localparam int CntW      = $clog2(VALUE_BITS + 1);
    localparam int LeftW     = $clog2(NumDigits + 1);

    logic [VALUE_BITS-1:0]            bin_reg;
    logic [BcdW-1:0]                  bcd_reg;
    logic [BcdW-1:0]                  bcd_adj;
    logic [CntW-1:0]                  bit_cnt_reg;
    logic [LeftW-1:0]                 left_reg;
    logic [b2da_pkg::CHAR_W-1:0]      char_reg;
    logic                             last_reg;
    logic                             valid_reg;
    logic                             valid_next;
    logic [b2da_pkg::DIGIT_W-1:0]     top_digit;

    assign top_digit = bcd_reg[BcdW-1 -: b2da_pkg::DIGIT_W];

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NumDigits; i++) begin
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::BCD_FIVE) begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::BCD_ADJ;
            end else begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg     <= in_value[VALUE_BITS-1:0];
            bcd_reg     <= '0;
            bit_cnt_reg <= CntW'(VALUE_BITS);
            left_reg    <= LeftW'(NumDigits);
        end else if (cmd.step) begin
            bin_reg     <= bin_reg << 1;
            bcd_reg     <= {bcd_adj[BcdW-2:0], bin_reg[VALUE_BITS-1]};
            bit_cnt_reg <= bit_cnt_reg - CntW'(1);
        end else if (cmd.skip || cmd.emit) begin
            bcd_reg  <= bcd_reg << b2da_pkg::DIGIT_W;
            left_reg <= left_reg - LeftW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            char_reg <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
            last_reg <= (left_reg == LeftW'(1));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign status.conv_last  = (bit_cnt_reg == CntW'(1));
    assign status.top_zero   = (top_digit == '0);
    assign status.digits_one = (left_reg == LeftW'(1));
    assign status.out_free   = !valid_reg || out_ready;

    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

### design/binary_to_decimal_ascii_top.sv
// top level of the binary to decimal ascii converter
//
// usage: an unsigned value enters on the s_ stream; only its low VALUE_BITS bits
// count. the decimal text leaves on the m_ stream as one transaction per digit,
// most significant first, leading zeros dropped, m_tlast on the final digit.
// zero gives the single character '0'.
// timing: the value is converted by shift-add-3, one bit per cycle, over all
// VALUE_BITS bits. leading zero digits are then dropped at one per cycle (up to
// digit count minus one of them), then output starts, and digits enter the
// output register at one per cycle while it is free.
// s_tready is high only while no conversion is in progress; a new value may be
// taken while the last digit still waits in the output register.
// a stalled receiver holds the current digit in the output register and
// pauses digit output; no digit is lost or repeated.
// reset clears the controller and the output valid flag; no value is pending.
`default_nettype none

module binary_to_decimal_ascii_top #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [b2da_pkg::MAX_IN_W-1:0]    s_tdata,  // [63:0] value
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [b2da_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [5:0] digit_char, [7:6] zero
    output logic                                  m_tlast
);

    b2da_pkg::b2da_cmd_t         cmd;
    b2da_pkg::b2da_status_t      status;
    logic [b2da_pkg::CHAR_W-1:0] out_char;

    b2da_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    b2da_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {2'b00, out_char};

endmodule

`default_nettype wire

### bench/binary_to_decimal_ascii_checker.sv
// checker for the binary to decimal ascii converter: predicts the digit text and compares it
`timescale 1ns / 100ps

module binary_to_decimal_ascii_checker #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [b2da_pkg::MAX_IN_W-1:0]      s_tdata,   // [63:0] value
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [b2da_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [5:0] digit_char, [7:6] zero
    input  wire logic                               m_tlast,
    output int                                      mismatch_count,
    output int                                      pending_digits
);

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } digit_t;

    localparam logic [b2da_pkg::MAX_IN_W-1:0] VALUE_MASK =
        (VALUE_BITS >= b2da_pkg::MAX_IN_W) ? {b2da_pkg::MAX_IN_W{1'b1}}
                                           : ((64'd1 << VALUE_BITS) - 64'd1);

    digit_t expected_digits[$];
    int     errors;

    // decimal text of one value, most significant digit first
    task automatic queue_decimal_text(input logic [b2da_pkg::MAX_IN_W-1:0] value);
        logic [b2da_pkg::MAX_IN_W-1:0] rest;
        logic [3:0]                    digits[20];
        int                            count;
        digit_t                        entry;
        rest  = value & VALUE_MASK;
        count = 0;
        if (rest == 0) begin
            digits[0] = 4'd0;
            count     = 1;
        end else begin
            while (rest != 0 && count < 20) begin
                digits[count] = 4'(rest % 64'd10);
                rest          = rest / 64'd10;
                count++;
            end
        end
        for (int k = count - 1; k >= 0; k--) begin
            entry.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits[k]);
            entry.last_digit = (k == 0);
            expected_digits.push_back(entry);
        end
    endtask

    initial begin
        errors         = 0;
        mismatch_count = 0;
        pending_digits = 0;
    end

    always @(posedge aclk) begin
        digit_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_decimal_text(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $display("%0t: unexpected digit transaction, got char %0d pad %0d last %0b",
                             $time, m_tdata[b2da_pkg::CHAR_W-1:0],
                             m_tdata[b2da_pkg::OUT_TDATA_W-1:b2da_pkg::CHAR_W], m_tlast);
                    errors++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_tdata != {{(b2da_pkg::OUT_TDATA_W-b2da_pkg::CHAR_W){1'b0}},
                                    want.digit_char}
                            || m_tlast != want.last_digit) begin
                        $display("%0t: digit mismatch, expected char %0d pad 0 last %0b,",
                                 $time, want.digit_char, want.last_digit,
                                 " got char %0d pad %0d last %0b",
                                 m_tdata[b2da_pkg::CHAR_W-1:0],
                                 m_tdata[b2da_pkg::OUT_TDATA_W-1:b2da_pkg::CHAR_W], m_tlast);
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        pending_digits <= expected_digits.size();
    end

endmodule

### bench/binary_to_decimal_ascii_top_test.sv
// testbench top for the binary to decimal ascii converter: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module binary_to_decimal_ascii_top_test;

    localparam int VALUE_BITS   = b2da_pkg::VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 390;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [b2da_pkg::MAX_IN_W-1:0]     s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [b2da_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                              m_tlast;
    int                                mismatch_count;
    int                                pending_digits;
    int                                quiet_cycles;
    int                                send_calm;
    int                                recv_calm;

    binary_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    binary_to_decimal_ascii_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_digits (pending_digits)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle cycles before the next transaction, with occasional stretches of none
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // mostly values of random bit length, some powers of ten or one below them, some all ones or zero
    function automatic logic [b2da_pkg::MAX_IN_W-1:0] random_value();
        logic [b2da_pkg::MAX_IN_W-1:0] raw;
        logic [b2da_pkg::MAX_IN_W-1:0] power;
        int                            pick;
        int                            len;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            power = 64'd1;
            repeat ($urandom_range(0, 19)) power = power * 64'd10;
            return $urandom_range(0, 1) ? power : power - 64'd1;
        end
        if (pick == 1) begin
            return $urandom_range(0, 1) ? {b2da_pkg::MAX_IN_W{1'b1}} : '0;
        end
        len = $urandom_range(1, b2da_pkg::MAX_IN_W);
        return raw >> (b2da_pkg::MAX_IN_W - len);
    endfunction

    task automatic send_value(input logic [b2da_pkg::MAX_IN_W-1:0] value);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    // result side: random stalls between digit transactions
    initial begin
        int gap;
        m_tready  = 1'b0;
        recv_calm = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [b2da_pkg::MAX_IN_W-1:0] directed_values[$] = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd255, 64'd1234567890,
            64'd4294967295, 64'd4294967296, 64'd9999999999999999999,
            64'd10000000000000000000, 64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd0, 64'd7
        };
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_calm = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (directed_values[i]) send_value(directed_values[i]);
        repeat (RANDOM_ITEMS) send_value(random_value());
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_digits != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_digits == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
